[src/cnq_pkg.sv]
// Shared types and constants for the context non-uniform quantizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cnq_pkg;

   localparam int LEVELS_DEF       = 8;
   localparam int MAX_WIDTH_DEF    = 1024;
   localparam int MAX_CHANNELS_DEF = 4;
   localparam int DATA_WIDTH_DEF   = 16;

   localparam int ADDR_FIELD_W = 12;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [10:0] WIDTH_RST  = 11'd1024;
   localparam logic [15:0] HEIGHT_RST = 16'd1024;
   localparam logic [2:0]  CHANS_RST  = 3'd1;

   typedef enum logic {
      ACT_TABLE = 1'b0,
      ACT_QUANT = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE   = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2,
      CSR_CHANS  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_LOW,
      ST_STEP,
      ST_SAVE,
      ST_CTX,
      ST_DONE
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic tbl_wr;
      logic walk_start;
      logic walk_low;
      logic walk_step;
      logic base_sel;
      logic save;
      logic ctx;
      logic finish;
   } cnq_cmd_type;

   typedef struct packed {
      logic low_neg;
      logic step_last;
      logic mode;
      logic out_free;
   } cnq_status_type;

endpackage

`default_nettype wire

[src/cnq_ctrl.sv]
// Controller state machine: sequences the table walks of one sample.
// Depends on cnq_pkg; drives the datapath through cnq_cmd_type.
`timescale 1ns / 1ps
`default_nettype none

module cnq_ctrl
   import cnq_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   input  wire logic           req_tuser,
   output logic                req_tready,
   input  wire cnq_status_type sts,
   output cnq_cmd_type         cmd
);

   ctl_state_type state_ff, state_in;
   logic          pass_ff, pass_in;
   logic          pass_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      cmd          = '0;
      cmd.base_sel = pass_ff;
      req_tready   = 1'b0;
      pass_end     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == ACT_QUANT) begin
                  cmd.capture = 1'b1;
                  pass_in     = 1'b0;
                  state_in    = ST_ISSUE;
               end else begin
                  cmd.tbl_wr = 1'b1;
               end
            end
         end
         ST_ISSUE: begin
            cmd.walk_start = 1'b1;
            state_in       = ST_LOW;
         end
         ST_LOW: begin
            cmd.walk_low = 1'b1;
            if (sts.low_neg) begin
               pass_end = 1'b1;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.walk_step = 1'b1;
            pass_end      = sts.step_last;
         end
         ST_SAVE: begin
            cmd.save = 1'b1;
            state_in = sts.mode ? ST_CTX : ST_DONE;
         end
         ST_CTX: begin
            cmd.ctx  = 1'b1;
            pass_in  = 1'b1;
            state_in = ST_ISSUE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (pass_end) begin
         state_in = pass_ff ? ST_DONE : ST_SAVE;
      end
   end

endmodule

`default_nettype wire

[src/cnq_dpath.sv]
// Datapath: level table, upper row store, walk arithmetic, counters, output stage.
// Depends on cnq_pkg; commanded by cnq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module cnq_dpath
   import cnq_pkg::*;
#(
   parameter int LEVELS       = LEVELS_DEF,
   parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
   localparam int IW          = $clog2(LEVELS)
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cnq_cmd_type             cmd,
   output cnq_status_type               sts,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [ADDR_FIELD_W-1:0] table_address,
   input  wire logic [DATA_WIDTH-1:0]   table_value,
   input  wire logic [DATA_WIDTH-1:0]   sample_value,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [IW-1:0]                level_index,
   output logic [DATA_WIDTH-1:0]        reconstructed_value
);

   localparam int DW        = DATA_WIDTH;
   localparam int NW        = $clog2(LEVELS + 1);
   localparam int CW        = $clog2(MAX_WIDTH);
   localparam int EW        = $clog2(MAX_WIDTH + 1);
   localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CHE_W     = $clog2(MAX_CHANNELS + 1);
   localparam int CHL_W     = $clog2(MAX_CHANNELS * LEVELS + 1);
   localparam int TBL_DEPTH = ((LEVELS + 1) * (LEVELS + 1) + 1) * MAX_CHANNELS * LEVELS;
   localparam int AW        = $clog2(TBL_DEPTH);
   localparam int CX_W      = $clog2((LEVELS + 1) * (LEVELS + 1) + 1);
   localparam int REM_W     = DW + $clog2(LEVELS) + 2;
   localparam int REC_W     = REM_W + 1;

   // configuration
   logic             mode_ff;
   logic [10:0]      width_ff;
   logic [15:0]      height_ff;
   logic [2:0]       chans_ff;
   logic [EW-1:0]    eff_w;
   logic [15:0]      eff_h;
   logic [CHE_W-1:0] eff_ch;
   logic [CHL_W-1:0] chl_ff;

   // stream position
   logic [CW-1:0]    col_ff;
   logic [15:0]      row_ff;
   logic [CH_W-1:0]  ch_ff;
   logic [IW-1:0]    left_ff;

   // memories
   logic [DW-1:0]    tbl_mem [TBL_DEPTH];
   logic [DW-1:0]    tbl_rd_ff;
   logic [IW-1:0]    up_mem [MAX_WIDTH];
   logic [IW-1:0]    up_rd_ff;
   logic             tbl_we, tbl_re;
   logic [AW-1:0]    tbl_raddr, walk_base;

   // walk
   logic [DW-1:0]    x_ff;
   logic [AW-1:0]    chan_base_ff, base2_ff, ptr_ff;
   logic [CX_W-1:0]  ctx1_ff;
   logic [REM_W-1:0] rem_ff, x_ext, data_ext, low_diff, rem_new;
   logic [REC_W-1:0] rnd_val, rec;
   logic [IW-1:0]    idx_ff, j_ff;
   logic             step_stop, round_down;
   logic [NW-1:0]    up_sel, left_sel;
   logic [DW-1:0]    rec_sat;

   // output stage
   logic             rsp_valid_ff;
   logic [IW-1:0]    rsp_idx_ff;
   logic [DW-1:0]    rsp_rec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         chans_ff  <= CHANS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:   mode_ff   <= csr_wdata[0];
            CSR_WIDTH:  width_ff  <= csr_wdata[10:0];
            CSR_HEIGHT: height_ff <= csr_wdata[15:0];
            CSR_CHANS:  chans_ff  <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == 11'd0) begin
         eff_w = EW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = EW'(width_ff);
      end
      eff_h = (height_ff == 16'd0) ? 16'd1 : height_ff;
      if (chans_ff == 3'd0) begin
         eff_ch = CHE_W'(1);
      end else if (32'(chans_ff) > MAX_CHANNELS) begin
         eff_ch = CHE_W'(MAX_CHANNELS);
      end else begin
         eff_ch = CHE_W'(chans_ff);
      end
   end

   always_ff @(posedge clock) begin
      chl_ff <= CHL_W'(32'(eff_ch) * LEVELS);
   end

   // table memory, one write and one registered read port
   assign tbl_we    = cmd.tbl_wr && (32'(table_address) < TBL_DEPTH);
   assign walk_base = cmd.base_sel ? base2_ff : chan_base_ff;
   assign tbl_raddr = cmd.walk_start ? walk_base : ptr_ff;
   assign tbl_re    = cmd.walk_start || cmd.walk_low || (cmd.walk_step && !step_stop);

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[AW'(table_address)] <= table_value;
      end
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[tbl_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.save) begin
         up_mem[col_ff] <= idx_ff;
      end
      if (cmd.capture) begin
         up_rd_ff <= up_mem[col_ff];
      end
   end

   // walk arithmetic
   always_comb begin
      x_ext      = {{(REM_W-DW){x_ff[DW-1]}}, x_ff};
      data_ext   = {{(REM_W-DW){tbl_rd_ff[DW-1]}}, tbl_rd_ff};
      low_diff   = x_ext - data_ext;
      rem_new    = rem_ff - data_ext;
      rnd_val    = {rem_ff, 1'b0} - {data_ext[REM_W-1], data_ext};
      round_down = rnd_val[REC_W-1];
      step_stop  = rem_new[REM_W-1] || (j_ff == IW'(LEVELS - 1));
      rec        = {x_ext[REM_W-1], x_ext} - {rem_ff[REM_W-1], rem_ff};
      if ((&rec[REC_W-1:DW-1]) || !(|rec[REC_W-1:DW-1])) begin
         rec_sat = rec[DW-1:0];
      end else if (rec[REC_W-1]) begin
         rec_sat = {1'b1, {(DW-1){1'b0}}};
      end else begin
         rec_sat = {1'b0, {(DW-1){1'b1}}};
      end
      up_sel   = (row_ff != 16'd0) ? NW'(up_rd_ff) : NW'(LEVELS);
      left_sel = (col_ff != CW'(0)) ? NW'(left_ff) : NW'(LEVELS);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff         <= sample_value;
         chan_base_ff <= AW'(ch_ff) * AW'(LEVELS);
      end
      if (cmd.walk_start) begin
         ptr_ff <= walk_base + AW'(1);
      end
      if (cmd.walk_low) begin
         rem_ff <= low_diff;
         idx_ff <= '0;
         j_ff   <= IW'(1);
         ptr_ff <= ptr_ff + AW'(1);
      end
      if (cmd.walk_step) begin
         if (step_stop) begin
            if (round_down) begin
               idx_ff <= j_ff - IW'(1);
            end else begin
               rem_ff <= rem_new;
               idx_ff <= j_ff;
            end
         end else begin
            rem_ff <= rem_new;
            j_ff   <= j_ff + IW'(1);
            ptr_ff <= ptr_ff + AW'(1);
         end
      end
      if (cmd.save) begin
         ctx1_ff <= CX_W'(up_sel) * CX_W'(LEVELS + 1) + CX_W'(left_sel) + CX_W'(1);
      end
      if (cmd.ctx) begin
         base2_ff <= AW'(ctx1_ff) * AW'(chl_ff) + chan_base_ff;
      end
   end

   // stream position, restarted by any register write
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         col_ff  <= '0;
         row_ff  <= '0;
         ch_ff   <= '0;
         left_ff <= '0;
      end else begin
         if (cmd.save) begin
            left_ff <= idx_ff;
         end
         if (cmd.finish) begin
            if ((EW'(col_ff) + EW'(1)) < eff_w) begin
               col_ff <= col_ff + CW'(1);
            end else begin
               col_ff <= '0;
               if (({1'b0, row_ff} + 17'd1) < {1'b0, eff_h}) begin
                  row_ff <= row_ff + 16'd1;
               end else begin
                  row_ff <= '0;
                  if ((CHE_W'(ch_ff) + CHE_W'(1)) < eff_ch) begin
                     ch_ff <= ch_ff + CH_W'(1);
                  end else begin
                     ch_ff <= '0;
                  end
               end
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_idx_ff <= idx_ff;
         rsp_rec_ff <= rec_sat;
      end
   end

   assign rsp_tvalid          = rsp_valid_ff;
   assign level_index         = rsp_idx_ff;
   assign reconstructed_value = rsp_rec_ff;

   assign sts.low_neg   = low_diff[REM_W-1];
   assign sts.step_last = step_stop;
   assign sts.mode      = mode_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

[src/context_nonuniform_quantizer.sv]
// Top level of the context non-uniform quantizer: request unpacking and wiring.
// Depends on cnq_pkg, cnq_ctrl and cnq_dpath.
//
//   Channel | Signals                           | Carries
//   request | req_tvalid/tready/tdata/tuser     | table write or sample to quantize
//   result  | rsp_tvalid/tready/tdata           | level index and reconstructed level
//   config  | csr_we/index/wdata                | mode, width, height, channel count
//
// A table write is taken in the idle state, which the block does not leave for it. A sample
// runs one table walk in mode 0 and two in mode 1, the second through the context table;
// each walk reads the level table through its single read port, one word a cycle.
// Reset is synchronous and clears control state only; the level table and upper row
// store hold unknown contents until written. A stalled result waits in the output
// register while the next request is taken; a finished sample waits only if it is full.
`timescale 1ns / 1ps
`default_nettype none

module context_nonuniform_quantizer
   import cnq_pkg::*;
#(
   parameter int LEVELS       = LEVELS_DEF,
   parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
   localparam int REQ_DATA_W  = ((ADDR_FIELD_W + 2 * DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_W  = (($clog2(LEVELS) + DATA_WIDTH + 7) / 8) * 8
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // table_address, table_value, sample_value
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // action
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // level_index, reconstructed_value
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW = $clog2(LEVELS);

   cnq_cmd_type              cmd;
   cnq_status_type           sts;
   logic [ADDR_FIELD_W-1:0]  table_address;
   logic [DATA_WIDTH-1:0]    table_value;
   logic [DATA_WIDTH-1:0]    sample_value;
   logic [IW-1:0]            level_index;
   logic [DATA_WIDTH-1:0]    reconstructed_value;

   assign table_address = req_tdata[ADDR_FIELD_W-1:0];
   assign table_value   = req_tdata[ADDR_FIELD_W +: DATA_WIDTH];
   assign sample_value  = req_tdata[ADDR_FIELD_W + DATA_WIDTH +: DATA_WIDTH];
   assign rsp_tdata     = RSP_DATA_W'({reconstructed_value, level_index});

   cnq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cnq_dpath #(
      .LEVELS       (LEVELS),
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS),
      .DATA_WIDTH   (DATA_WIDTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .table_address       (table_address),
      .table_value         (table_value),
      .sample_value        (sample_value),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .level_index         (level_index),
      .reconstructed_value (reconstructed_value)
   );

endmodule

`default_nettype wire

[src/cnq_checker.sv]
// Port-level checks of the context non-uniform quantizer, bound to the top level.
// Depends on cnq_pkg and context_nonuniform_quantizer.
`timescale 1ns / 1ps
`default_nettype none

module cnq_port_checks
   import cnq_pkg::*;
#(
   parameter int RSP_DATA_W = 24
)
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic req_fire;

   assign req_fire = req_tvalid && req_tready;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // a quantize request occupies the block
   a_quant_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == ACT_QUANT) |=> !req_tready)
      else $error("request taken while a sample is in work");

   // a table write completes in its own cycle
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == ACT_TABLE) |=> req_tready)
      else $error("table write blocked the request side");

   // a new result comes only out of a sample in work
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without a sample in work");

endmodule

bind context_nonuniform_quantizer cnq_port_checks #(
   .RSP_DATA_W (RSP_DATA_W)
) u_cnq_port_checks (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[test/cnq_checker.sv]
// Result checker for the context non-uniform quantizer testbench.
// Watches the request, result and config channels, predicts each level from its
// own copy of the tables and stream position, and counts mismatches. Needs cnq_pkg.
`timescale 1ns / 1ps

module cnq_checker
   import cnq_pkg::*;
#(
   parameter int REQ_W = ((ADDR_FIELD_W + 2 * DATA_WIDTH_DEF + 7) / 8) * 8,
   parameter int RSP_W = (($clog2(LEVELS_DEF) + DATA_WIDTH_DEF + 7) / 8) * 8
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   // table_address, table_value, sample_value
   input  wire logic [REQ_W-1:0]      req_tdata,
   // action
   input  wire logic                  req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // level_index, reconstructed_value
   input  wire logic [RSP_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         mismatch_count,
   output int                         pending_count
);

   localparam int LV          = LEVELS_DEF;
   localparam int LVW         = $clog2(LEVELS_DEF);
   localparam int DW          = DATA_WIDTH_DEF;
   localparam int MAX_W       = MAX_WIDTH_DEF;
   localparam int MAX_CH      = MAX_CHANNELS_DEF;
   localparam int TABLE_WORDS = ((LV + 1) * (LV + 1) + 1) * MAX_CH * LV;
   localparam longint SAT_HI  = (longint'(1) << (DW - 1)) - 1;
   localparam longint SAT_LO  = -SAT_HI - 1;

   typedef struct packed {
      logic [DW-1:0]  level_value;
      logic [LVW-1:0] level_index;
   } quant_result_type;

   logic signed [DW-1:0] level_words [TABLE_WORDS];
   int                   upper_codes [MAX_W];
   int                   left_code;
   int                   col_pos;
   int                   row_pos;
   int                   plane_pos;
   logic                 mode_q;
   logic [10:0]          width_q;
   logic [15:0]          height_q;
   logic [2:0]           chans_q;
   quant_result_type     quant_expect [$];

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Subtract the lowest level, then steps until the remainder goes negative,
   // and round to the nearer neighbor (upper one on a tie).
   function automatic void walk_levels(input int base, input longint sample,
                                       output int idx, output longint level);
      longint rem;
      longint step;
      int     j;
      bit     crossed;
      rem = sample - level_words[base];
      if (rem < 0) begin
         idx   = 0;
         level = level_words[base];
         return;
      end
      j       = 1;
      crossed = 1'b0;
      while (j < LV && !crossed) begin
         rem = rem - level_words[base + j];
         if (rem < 0) begin
            crossed = 1'b1;
         end else begin
            j++;
         end
      end
      if (j == LV) begin
         j--;
      end
      step = level_words[base + j];
      if (rem + rem + step < 0) begin
         rem = rem + step;
         j--;
      end
      idx   = j;
      level = sample - rem;
   endfunction

   always @(posedge clock) begin : watch
      quant_result_type got;
      quant_result_type want;
      int               eff_w;
      int               eff_h;
      int               eff_ch;
      int               col;
      int               plane;
      int               coarse;
      int               fine;
      int               up_code;
      int               side_code;
      int               base;
      longint           sample;
      longint           level;
      if (reset) begin
         mode_q         = 1'b0;
         width_q        = WIDTH_RST;
         height_q       = HEIGHT_RST;
         chans_q        = CHANS_RST;
         left_code      = 0;
         col_pos        = 0;
         row_pos        = 0;
         plane_pos      = 0;
         mismatch_count = 0;
         quant_expect.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[LVW+DW-1:0];
            if (quant_expect.size() == 0) begin
               report_mismatch($sformatf("result index %0d value %0d with none pending",
                                         got.level_index, $signed(got.level_value)));
            end else begin
               want = quant_expect.pop_front();
               if (got.level_index != want.level_index) begin
                  report_mismatch($sformatf("level_index got %0d expected %0d",
                                            got.level_index, want.level_index));
               end
               if (got.level_value != want.level_value) begin
                  report_mismatch($sformatf("reconstructed_value got %0d expected %0d",
                                            $signed(got.level_value),
                                            $signed(want.level_value)));
               end
            end
         end
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_MODE:   mode_q   = csr_wdata[0];
               CSR_WIDTH:  width_q  = csr_wdata[10:0];
               CSR_HEIGHT: height_q = csr_wdata[15:0];
               CSR_CHANS:  chans_q  = csr_wdata[2:0];
               default: ;
            endcase
            left_code = 0;
            col_pos   = 0;
            row_pos   = 0;
            plane_pos = 0;
         end
         if (req_tvalid && req_tready) begin
            if (action_type'(req_tuser) == ACT_TABLE) begin
               if (req_tdata[ADDR_FIELD_W-1:0] < TABLE_WORDS) begin
                  level_words[req_tdata[ADDR_FIELD_W-1:0]] = req_tdata[ADDR_FIELD_W +: DW];
               end
            end else begin
               eff_w  = (width_q == 0) ? 1 : ((width_q > MAX_W) ? MAX_W : width_q);
               eff_h  = (height_q == 0) ? 1 : height_q;
               eff_ch = (chans_q == 0) ? 1 : ((chans_q > MAX_CH) ? MAX_CH : chans_q);
               col    = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
               plane  = (plane_pos < eff_ch) ? plane_pos : eff_ch - 1;
               sample = $signed(req_tdata[ADDR_FIELD_W + DW +: DW]);
               walk_levels(plane * LV, sample, coarse, level);
               fine = coarse;
               if (mode_q) begin
                  up_code   = (row_pos > 0) ? upper_codes[col] : LV;
                  side_code = (col > 0) ? left_code : LV;
                  base      = LV * eff_ch + (up_code * (LV + 1) + side_code) * eff_ch * LV
                              + plane * LV;
                  walk_levels(base, sample, fine, level);
               end
               upper_codes[col] = coarse;
               left_code        = coarse;
               if (col + 1 < eff_w) begin
                  col_pos = col + 1;
               end else begin
                  col_pos = 0;
                  if (row_pos + 1 < eff_h) begin
                     row_pos = row_pos + 1;
                  end else begin
                     row_pos   = 0;
                     plane_pos = (plane + 1 < eff_ch) ? plane + 1 : 0;
                  end
               end
               if (level > SAT_HI) begin
                  level = SAT_HI;
               end else if (level < SAT_LO) begin
                  level = SAT_LO;
               end
               want.level_index = LVW'(fine);
               want.level_value = level[DW-1:0];
               quant_expect.push_back(want);
            end
         end
      end
      pending_count <= quant_expect.size();
   end

endmodule

[test/tb_context_nonuniform_quantizer.sv]
// Testbench top for the context non-uniform quantizer: clock, reset, request and
// config stimulus, result backpressure and the verdict. Needs cnq_pkg, the block
// and cnq_checker, which does the prediction and comparison.
`timescale 1ns / 1ps

module tb_context_nonuniform_quantizer;
   import cnq_pkg::*;

   localparam int REQ_W        = ((ADDR_FIELD_W + 2 * DATA_WIDTH_DEF + 7) / 8) * 8;
   localparam int RSP_W        = (($clog2(LEVELS_DEF) + DATA_WIDTH_DEF + 7) / 8) * 8;
   localparam int LV           = LEVELS_DEF;
   localparam int TABLE_WORDS  = ((LV + 1) * (LV + 1) + 1) * MAX_CHANNELS_DEF * LV;
   localparam int RANDOM_ITEMS = 1550;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 1500000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // table_address, table_value, sample_value
   logic [REQ_W-1:0]      req_tdata  = '0;
   // action
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // level_index, reconstructed_value
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   bit                    quiet      = 1'b0;
   int                    cycle_count = 0;
   int                    results_owed;
   int                    mismatch_total;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   context_nonuniform_quantizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   cnq_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_total),
      .pending_count  (results_owed)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL context_nonuniform_quantizer");
         $finish;
      end
   end

   // Result side: stall a random number of cycles before taking each result.
   initial begin
      int stall;
      @(posedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_request(input action_type act, input logic [11:0] addr,
                               input logic [15:0] tval, input logic [15:0] sval);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= REQ_W'({sval, tval, addr});
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_word(input int addr, input logic [15:0] val);
      send_request(ACT_TABLE, 12'(addr), val, 16'($urandom));
   endtask

   task automatic quantize_sample(input logic [15:0] val);
      send_request(ACT_QUANT, 12'($urandom), 16'($urandom), val);
   endtask

   // Hold off until every result is back and the block has gone quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all four registers in a rotated order, with junk above the mode, width and channel fields.
   task automatic program_stream(input logic m, input logic [10:0] w,
                                 input logic [15:0] h, input logic [2:0] ch);
      logic [15:0] val [4];
      int          first;
      int          k;
      val[CSR_MODE]   = {15'($urandom), m};
      val[CSR_WIDTH]  = {5'($urandom), w};
      val[CSR_HEIGHT] = h;
      val[CSR_CHANS]  = {13'($urandom), ch};
      first = $urandom_range(0, 3);
      for (k = 0; k < 4; k++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'((first + k) % 4);
         csr_wdata <= val[(first + k) % 4];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      int          addr;
      int          phase;
      int          burst;
      int          k;
      int          items_done;
      logic [15:0] word;
      logic        cfg_m;
      logic [10:0] cfg_w;
      logic [15:0] cfg_h;
      logic [2:0]  cfg_ch;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Fill every table word: lowest levels mostly at or below zero, steps mostly positive.
      for (addr = 0; addr < TABLE_WORDS; addr++) begin
         if (addr % 256 == 0) begin
            quiet = $urandom_range(0, 1);
         end
         if ($urandom_range(0, 39) == 0) begin
            word = 16'($urandom);
         end else if (addr % LV == 0) begin
            word = 16'(0 - $urandom_range(0, 12000));
         end else begin
            word = 16'($urandom_range(1, 4000));
         end
         write_word(addr, word);
      end
      quiet = 1'b0;
      settle();

      // Directed: even set, extremes, ties, dropped writes, saturation.
      program_stream(1'b0, 11'd4, 16'd2, 3'd1);
      write_word(0, -16'sd1024);
      for (k = 1; k < LV; k++) begin
         write_word(k, 16'd256);
      end
      write_word(TABLE_WORDS, 16'h7FFF);
      write_word(4095, 16'h8000);
      quantize_sample(16'h8000);
      quantize_sample(16'h7FFF);
      quantize_sample(16'h0000);
      quantize_sample(-16'sd896);
      quantize_sample(-16'sd897);
      write_word(0, 16'sd32000);
      write_word(1, 16'sd1000);
      quantize_sample(16'h7FFF);
      write_word(0, -16'sd32000);
      write_word(1, 16'h8000);
      quantize_sample(-16'sd100);

      items_done = 0;
      phase      = 0;
      while (items_done < RANDOM_ITEMS) begin
         settle();
         case (phase)
            0: begin cfg_m = 1'b1; cfg_w = 11'd0;    cfg_h = 16'd0;     cfg_ch = 3'd0; end
            1: begin cfg_m = 1'b1; cfg_w = 11'd1024; cfg_h = 16'hFFFF;  cfg_ch = 3'd4; end
            2: begin cfg_m = 1'b0; cfg_w = 11'd2047; cfg_h = 16'd1;     cfg_ch = 3'd7; end
            3: begin cfg_m = 1'b1; cfg_w = 11'd3;    cfg_h = 16'd0;     cfg_ch = 3'd5; end
            4: begin cfg_m = 1'b1; cfg_w = 11'd1;    cfg_h = 16'hFFFF;  cfg_ch = 3'd1; end
            5: begin cfg_m = 1'b0; cfg_w = 11'd1;    cfg_h = 16'd1;     cfg_ch = 3'd2; end
            default: begin
               cfg_m = $urandom_range(0, 1);
               case ($urandom_range(0, 15))
                  0:       cfg_w = 11'd0;
                  1:       cfg_w = 11'($urandom_range(1025, 2047));
                  default: cfg_w = 11'($urandom_range(1, 12));
               endcase
               cfg_h  = 16'($urandom_range(0, 6));
               cfg_ch = 3'($urandom_range(0, 7));
            end
         endcase
         program_stream(cfg_m, cfg_w, cfg_h, cfg_ch);
         quiet = ($urandom_range(0, 3) == 0);
         burst = $urandom_range(40, 160);
         for (k = 0; k < burst; k++) begin
            if ($urandom_range(0, 11) == 0) begin
               addr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                  : $urandom_range(0, TABLE_WORDS - 1);
               write_word(addr, 16'($urandom));
               if (addr < TABLE_WORDS) begin
                  items_done++;
               end
            end else begin
               if ($urandom_range(0, 7) == 0) begin
                  word = 16'($urandom);
               end else begin
                  word = 16'($urandom_range(0, 32000) - 16000);
               end
               quantize_sample(word);
               items_done++;
            end
         end
         phase++;
      end

      quiet = 1'b0;
      settle();
      if (mismatch_total == 0 && results_owed == 0) begin
         $display("PASS context_nonuniform_quantizer");
      end else begin
         $display("FAIL context_nonuniform_quantizer");
      end
      $finish;
   end

endmodule
